// ===== rtl/lfa_pkg.sv =====
// shared types and constants for the lifo free list allocator
package lfa_pkg;

   localparam int IDX_W   = 7;   // buffer_index, pool size and counts
   localparam int GRANT_W = 6;   // granted_index
   localparam int STS_W   = 2;

   localparam logic [STS_W-1:0] STS_OK        = 2'd0;
   localparam logic [STS_W-1:0] STS_EXHAUSTED = 2'd1;
   localparam logic [STS_W-1:0] STS_RANGE     = 2'd2;
   localparam logic [STS_W-1:0] STS_DUPLICATE = 2'd3;

   localparam logic KIND_ACQUIRE = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   typedef struct packed {
      logic reload;
      logic sweep_step;
      logic capture;
      logic commit;
   } ctl_cmd_type;

   typedef struct packed {
      logic sweep_last;
   } dp_sts_type;

endpackage

// ===== rtl/lifo_free_list_allocator.sv =====
// lifo free list allocator top level: controller plus datapath
//
// Hands out buffer indices from a pool kept as a last-in-first-out stack.
// req channel: req_kind 0 acquires an index, 1 releases req_buffer_index.
// rsp channel: one item per request with status (ok, exhausted, out of
// range, already free), the granted index and the free and in-use counts.
// csr port: csr_wr_en with csr_wr_data sets the pool size (0 taken as 1,
// above the capacity taken as the capacity) and reloads the pool.
// Each item passes a capture step, which reads the stack top and free
// mark from their memories, and an execute step, which decides and writes
// back and loads the result register; a new item is taken only after the
// last one has left execute. The result register holds one finished item;
// while the receiver stalls it, the next item is taken and waits in
// execute until it drains. After reset, and after every pool size write,
// a sweep refills the stack and free marks, one entry per cycle, up to the
// pool size (64 after reset by default), with req_stall high.
module lifo_free_list_allocator #(
   parameter int POOL_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_kind,
   input  logic [lfa_pkg::IDX_W-1:0]           req_buffer_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lfa_pkg::STS_W-1:0]           rsp_status,
   output logic [lfa_pkg::GRANT_W-1:0]         rsp_granted_index,
   output logic [lfa_pkg::IDX_W-1:0]           rsp_free_count,
   output logic [lfa_pkg::IDX_W-1:0]           rsp_active_count,
   input  logic                                csr_wr_en,
   input  logic [lfa_pkg::IDX_W-1:0]           csr_wr_data
);

   lfa_pkg::ctl_cmd_type cmd;
   lfa_pkg::dp_sts_type  sts;

   lfa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .csr_wr_en(csr_wr_en),
      .sts      (sts),
      .cmd      (cmd)
   );

   lfa_dp #(
      .POOL_DEPTH(POOL_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_wr_data      (csr_wr_data),
      .req_kind         (req_kind),
      .req_buffer_index (req_buffer_index),
      .rsp_status       (rsp_status),
      .rsp_granted_index(rsp_granted_index),
      .rsp_free_count   (rsp_free_count),
      .rsp_active_count (rsp_active_count)
   );

endmodule

// ===== rtl/lfa_ram.sv =====
// generic single write port ram with registered read
module lfa_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lfa_ctrl.sv =====
// controller: reload sweep, item capture, execute and result handshake
module lfa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 csr_wr_en,
   input  lfa_pkg::dp_sts_type  sts,
   output lfa_pkg::ctl_cmd_type cmd
);

   localparam logic [1:0] S_SWEEP = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || csr_wr_en;
   assign accept    = req_valid && (state_ff == S_IDLE) && !csr_wr_en;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.reload     = csr_wr_en;
      unique case (state_ff)
         S_SWEEP: begin
            if (!csr_wr_en) begin
               cmd.sweep_step = 1'b1;
               if (sts.sweep_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_SWEEP;
         end
      endcase
      if (csr_wr_en) begin
         state_in = S_SWEEP;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/lfa_dp.sv =====
// datapath: pool size, counts, free stack and free-mark memories, result register
module lfa_dp #(
   parameter int POOL_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lfa_pkg::ctl_cmd_type                cmd,
   output lfa_pkg::dp_sts_type                 sts,
   input  logic [lfa_pkg::IDX_W-1:0]           csr_wr_data,
   input  logic                                req_kind,
   input  logic [lfa_pkg::IDX_W-1:0]           req_buffer_index,
   output logic [lfa_pkg::STS_W-1:0]           rsp_status,
   output logic [lfa_pkg::GRANT_W-1:0]         rsp_granted_index,
   output logic [lfa_pkg::IDX_W-1:0]           rsp_free_count,
   output logic [lfa_pkg::IDX_W-1:0]           rsp_active_count
);

   localparam int ADDR_W  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int CAP     = (POOL_DEPTH < 127) ? POOL_DEPTH : 127;
   localparam int RST_SZ  = (CAP < 64) ? CAP : 64;
   localparam logic [lfa_pkg::IDX_W-1:0] CAP_V    = lfa_pkg::IDX_W'(CAP);
   localparam logic [lfa_pkg::IDX_W-1:0] RST_SZ_V = lfa_pkg::IDX_W'(RST_SZ);
   localparam logic [lfa_pkg::IDX_W-1:0] ONE_V    = lfa_pkg::IDX_W'(1);

   logic [lfa_pkg::IDX_W-1:0] pool_ff, pool_in;
   logic [lfa_pkg::IDX_W-1:0] fill_ff, fill_in;
   logic [lfa_pkg::IDX_W-1:0] inuse_ff, inuse_in;
   logic [lfa_pkg::IDX_W-1:0] sweep_ff, sweep_in;
   logic                      kind_ff;
   logic [lfa_pkg::IDX_W-1:0] idx_ff;
   logic [lfa_pkg::STS_W-1:0]   status_ff, status_in;
   logic [lfa_pkg::GRANT_W-1:0] grant_ff, grant_in;
   logic [lfa_pkg::IDX_W-1:0]   free_ff;
   logic [lfa_pkg::IDX_W-1:0]   active_ff;
   logic [lfa_pkg::IDX_W-1:0] size_clamped;

   logic                      stk_wr_en;
   logic [ADDR_W-1:0]         stk_wr_addr;
   logic [lfa_pkg::IDX_W-1:0] stk_wr_data;
   logic [ADDR_W-1:0]         stk_rd_addr;
   logic [lfa_pkg::IDX_W-1:0] stk_rd_data;
   logic                      mark_wr_en;
   logic [ADDR_W-1:0]         mark_wr_addr;
   logic                      mark_wr_data;
   logic [ADDR_W-1:0]         mark_rd_addr;
   logic                      mark_rd_data;

   // written value of zero means one, above the capacity means the capacity
   always_comb begin
      size_clamped = csr_wr_data;
      if (csr_wr_data == '0) begin
         size_clamped = ONE_V;
      end else if (csr_wr_data > CAP_V) begin
         size_clamped = CAP_V;
      end
   end

   assign sts.sweep_last = (sweep_ff == pool_ff - ONE_V);

   // read addresses: top of stack always, mark from the port when an item is taken
   assign stk_rd_addr  = ADDR_W'(fill_ff - ONE_V);
   assign mark_rd_addr = cmd.capture ? ADDR_W'(req_buffer_index) : ADDR_W'(idx_ff);

   always_comb begin
      pool_in      = pool_ff;
      fill_in      = fill_ff;
      inuse_in     = inuse_ff;
      sweep_in     = sweep_ff;
      status_in    = lfa_pkg::STS_OK;
      grant_in     = '0;
      stk_wr_en    = 1'b0;
      stk_wr_addr  = ADDR_W'(sweep_ff);
      stk_wr_data  = sweep_ff;
      mark_wr_en   = 1'b0;
      mark_wr_addr = ADDR_W'(sweep_ff);
      mark_wr_data = 1'b1;

      if (kind_ff == lfa_pkg::KIND_ACQUIRE) begin
         if (fill_ff == '0) begin
            status_in = lfa_pkg::STS_EXHAUSTED;
         end else begin
            grant_in = stk_rd_data[lfa_pkg::GRANT_W-1:0];
            if (cmd.commit) begin
               fill_in      = fill_ff - ONE_V;
               inuse_in     = inuse_ff + ONE_V;
               mark_wr_en   = 1'b1;
               mark_wr_addr = ADDR_W'(stk_rd_data);
               mark_wr_data = 1'b0;
            end
         end
      end else begin
         if (idx_ff >= pool_ff) begin
            status_in = lfa_pkg::STS_RANGE;
         end else if (mark_rd_data) begin
            status_in = lfa_pkg::STS_DUPLICATE;
         end else if (cmd.commit) begin
            // guards never fire while fill plus in-use equals the pool size
            if (fill_ff < CAP_V) begin
               fill_in      = fill_ff + ONE_V;
               stk_wr_en    = 1'b1;
               stk_wr_addr  = ADDR_W'(fill_ff);
               stk_wr_data  = idx_ff;
               mark_wr_en   = 1'b1;
               mark_wr_addr = ADDR_W'(idx_ff);
               mark_wr_data = 1'b1;
            end
            if (inuse_ff != '0) begin
               inuse_in = inuse_ff - ONE_V;
            end
         end
      end

      if (cmd.sweep_step) begin
         stk_wr_en  = 1'b1;
         mark_wr_en = 1'b1;
         sweep_in   = sweep_ff + ONE_V;
      end

      if (cmd.reload) begin
         pool_in    = size_clamped;
         fill_in    = size_clamped;
         inuse_in   = '0;
         sweep_in   = '0;
         stk_wr_en  = 1'b0;
         mark_wr_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff  <= RST_SZ_V;
         fill_ff  <= RST_SZ_V;
         inuse_ff <= '0;
         sweep_ff <= '0;
      end else begin
         pool_ff  <= pool_in;
         fill_ff  <= fill_in;
         inuse_ff <= inuse_in;
         sweep_ff <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         idx_ff  <= req_buffer_index;
      end
      if (cmd.commit) begin
         status_ff <= status_in;
         grant_ff  <= grant_in;
         free_ff   <= fill_in;
         active_ff <= inuse_in;
      end
   end

   lfa_ram #(
      .WIDTH(lfa_pkg::IDX_W),
      .DEPTH(POOL_DEPTH)
   ) u_stack (
      .clock  (clock),
      .wr_en  (stk_wr_en),
      .wr_addr(stk_wr_addr),
      .wr_data(stk_wr_data),
      .rd_addr(stk_rd_addr),
      .rd_data(stk_rd_data)
   );

   lfa_ram #(
      .WIDTH(1),
      .DEPTH(POOL_DEPTH)
   ) u_mark (
      .clock  (clock),
      .wr_en  (mark_wr_en),
      .wr_addr(mark_wr_addr),
      .wr_data(mark_wr_data),
      .rd_addr(mark_rd_addr),
      .rd_data(mark_rd_data)
   );

   assign rsp_status        = status_ff;
   assign rsp_granted_index = grant_ff;
   assign rsp_free_count    = free_ff;
   assign rsp_active_count  = active_ff;

endmodule
